[rtl/sha_pkg.sv]
// Package with the SHA-256 word type, constants and round helper functions.
`default_nettype none

package sha_pkg;

   typedef logic [31:0] word_type;

   localparam int NumHashWords  = 8;
   localparam int NumBlockWords = 16;
   localparam int NumRounds     = 64;

   localparam logic [7:0] PadByte = 8'h80;

   // Byte slot from which the length no longer fits into the current block.
   localparam logic [5:0] LengthSlot = 6'd56;

   function automatic word_type init_value(input logic [2:0] idx);
      word_type value;
      case (idx)
         3'd0:    value = 32'h6a09e667;
         3'd1:    value = 32'hbb67ae85;
         3'd2:    value = 32'h3c6ef372;
         3'd3:    value = 32'ha54ff53a;
         3'd4:    value = 32'h510e527f;
         3'd5:    value = 32'h9b05688c;
         3'd6:    value = 32'h1f83d9ab;
         default: value = 32'h5be0cd19;
      endcase
      return value;
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type value;
      case (idx)
         6'd0:  value = 32'h428a2f98;  6'd1:  value = 32'h71374491;
         6'd2:  value = 32'hb5c0fbcf;  6'd3:  value = 32'he9b5dba5;
         6'd4:  value = 32'h3956c25b;  6'd5:  value = 32'h59f111f1;
         6'd6:  value = 32'h923f82a4;  6'd7:  value = 32'hab1c5ed5;
         6'd8:  value = 32'hd807aa98;  6'd9:  value = 32'h12835b01;
         6'd10: value = 32'h243185be;  6'd11: value = 32'h550c7dc3;
         6'd12: value = 32'h72be5d74;  6'd13: value = 32'h80deb1fe;
         6'd14: value = 32'h9bdc06a7;  6'd15: value = 32'hc19bf174;
         6'd16: value = 32'he49b69c1;  6'd17: value = 32'hefbe4786;
         6'd18: value = 32'h0fc19dc6;  6'd19: value = 32'h240ca1cc;
         6'd20: value = 32'h2de92c6f;  6'd21: value = 32'h4a7484aa;
         6'd22: value = 32'h5cb0a9dc;  6'd23: value = 32'h76f988da;
         6'd24: value = 32'h983e5152;  6'd25: value = 32'ha831c66d;
         6'd26: value = 32'hb00327c8;  6'd27: value = 32'hbf597fc7;
         6'd28: value = 32'hc6e00bf3;  6'd29: value = 32'hd5a79147;
         6'd30: value = 32'h06ca6351;  6'd31: value = 32'h14292967;
         6'd32: value = 32'h27b70a85;  6'd33: value = 32'h2e1b2138;
         6'd34: value = 32'h4d2c6dfc;  6'd35: value = 32'h53380d13;
         6'd36: value = 32'h650a7354;  6'd37: value = 32'h766a0abb;
         6'd38: value = 32'h81c2c92e;  6'd39: value = 32'h92722c85;
         6'd40: value = 32'ha2bfe8a1;  6'd41: value = 32'ha81a664b;
         6'd42: value = 32'hc24b8b70;  6'd43: value = 32'hc76c51a3;
         6'd44: value = 32'hd192e819;  6'd45: value = 32'hd6990624;
         6'd46: value = 32'hf40e3585;  6'd47: value = 32'h106aa070;
         6'd48: value = 32'h19a4c116;  6'd49: value = 32'h1e376c08;
         6'd50: value = 32'h2748774c;  6'd51: value = 32'h34b0bcb5;
         6'd52: value = 32'h391c0cb3;  6'd53: value = 32'h4ed8aa4a;
         6'd54: value = 32'h5b9cca4f;  6'd55: value = 32'h682e6ff3;
         6'd56: value = 32'h748f82ee;  6'd57: value = 32'h78a5636f;
         6'd58: value = 32'h84c87814;  6'd59: value = 32'h8cc70208;
         6'd60: value = 32'h90befffa;  6'd61: value = 32'ha4506ceb;
         6'd62: value = 32'hbef9a3f7;  default: value = 32'hc67178f2;
      endcase
      return value;
   endfunction

   function automatic word_type ror32(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

[rtl/sha256_stream_hasher.sv]
// Top level of the SHA-256 stream hasher: byte packing, padding and round sequencer.
`default_nettype none

// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall  data_byte, has_byte, end_of_message
// rsp_      out        rsp_valid/rsp_stall  digest_word, word_index, last_word
//
// A byte that does not complete a block is taken while the hasher is idle. The byte that fills
// a block starts a compression (one load, 64 rounds, one add), and no further transaction is
// taken until it has finished. An end of message adds a padding step and one compression, or,
// when the length needs a block of its own, a length step and a second compression; eight
// result transactions follow. Reset loads the initial hash value. req_stall is high while
// busy; a stalled result transaction holds its payload.
module sha256_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   // Sequencer states.
   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StLoad  = 3'd1;
   localparam logic [2:0] StRound = 3'd2;
   localparam logic [2:0] StAdd   = 3'd3;
   localparam logic [2:0] StPad   = 3'd4;
   localparam logic [2:0] StLen   = 3'd5;
   localparam logic [2:0] StOut   = 3'd6;

   // Where the sequencer goes once a compression is finished.
   localparam logic [1:0] RetIdle = 2'd0;
   localparam logic [1:0] RetPad  = 2'd1;
   localparam logic [1:0] RetLen  = 2'd2;
   localparam logic [1:0] RetOut  = 2'd3;

   localparam int RoundBits = $clog2(sha_pkg::NumRounds);

   logic [2:0]            state_ff, state_in;
   logic [1:0]            ret_ff, ret_in;
   logic [RoundBits-1:0]  round_ff, round_in;
   logic [2:0]            out_index_ff, out_index_in;
   logic [63:0]           bit_count_ff, bit_count_in;

   sha_pkg::word_type hash_ff  [sha_pkg::NumHashWords];
   sha_pkg::word_type hash_in  [sha_pkg::NumHashWords];
   sha_pkg::word_type work_ff  [sha_pkg::NumHashWords];
   sha_pkg::word_type work_in  [sha_pkg::NumHashWords];

   // The block buffer doubles as the message schedule window: during a compression it
   // shifts down by one word a round, so entry 0 always holds the current schedule word.
   sha_pkg::word_type block_ff [sha_pkg::NumBlockWords];
   sha_pkg::word_type block_in [sha_pkg::NumBlockWords];

   logic                 req_accept;
   logic                 rsp_accept;
   logic [5:0]           byte_slot;
   logic [3:0]           slot_word;
   logic [1:0]           slot_sub;
   sha_pkg::word_type    t1, t2, next_schedule;

   // Place a byte at a given position of a word; the bytes after it are cleared.
   function automatic sha_pkg::word_type put_byte(input sha_pkg::word_type old,
                                                  input logic [1:0] sub,
                                                  input logic [7:0] value);
      sha_pkg::word_type result;
      case (sub)
         2'd0:    result = {value, 24'h000000};
         2'd1:    result = {old[31:24], value, 16'h0000};
         2'd2:    result = {old[31:16], value, 8'h00};
         default: result = {old[31:8], value};
      endcase
      return result;
   endfunction

   assign req_stall  = (state_ff != StIdle);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == StOut);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign rsp_digest_word = hash_ff[out_index_ff];
   assign rsp_word_index  = out_index_ff;
   assign rsp_last_word   = (out_index_ff == 3'd7);

   assign byte_slot = bit_count_ff[8:3];
   assign slot_word = byte_slot[5:2];
   assign slot_sub  = byte_slot[1:0];

   // The shared round datapath.
   assign t1 = work_ff[7] + sha_pkg::big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + sha_pkg::round_k(round_ff) + block_ff[0];
   assign t2 = sha_pkg::big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));
   assign next_schedule = sha_pkg::small_sigma1(block_ff[14]) + block_ff[9]
                        + sha_pkg::small_sigma0(block_ff[1]) + block_ff[0];

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      out_index_in = out_index_ff;
      bit_count_in = bit_count_ff;
      hash_in      = hash_ff;
      work_in      = work_ff;
      block_in     = block_ff;

      case (state_ff)
         StIdle: begin
            if (req_accept) begin
               if (req_has_byte) begin
                  block_in[slot_word] = put_byte(block_ff[slot_word], slot_sub, req_data_byte);
                  bit_count_in = bit_count_ff + 64'd8;
                  if (byte_slot == 6'd63) begin
                     // The block is full: compress it before anything else.
                     state_in = StLoad;
                     ret_in   = req_end_of_message ? RetPad : RetIdle;
                  end else if (req_end_of_message) begin
                     state_in = StPad;
                  end
               end else if (req_end_of_message) begin
                  state_in = StPad;
               end
            end
         end
         StPad: begin
            block_in[slot_word] = put_byte(block_ff[slot_word], slot_sub, sha_pkg::PadByte);
            for (int i = 0; i < sha_pkg::NumBlockWords; i++) begin
               if (4'(i) > slot_word) begin
                  block_in[i] = '0;
               end
            end
            state_in = StLoad;
            if (byte_slot >= sha_pkg::LengthSlot) begin
               // No room for the length; it goes into an extra block.
               ret_in = RetLen;
            end else begin
               block_in[14] = bit_count_ff[63:32];
               block_in[15] = bit_count_ff[31:0];
               ret_in       = RetOut;
            end
         end
         StLen: begin
            for (int i = 0; i < sha_pkg::NumBlockWords - 2; i++) begin
               block_in[i] = '0;
            end
            block_in[14] = bit_count_ff[63:32];
            block_in[15] = bit_count_ff[31:0];
            state_in     = StLoad;
            ret_in       = RetOut;
         end
         StLoad: begin
            work_in  = hash_ff;
            round_in = '0;
            state_in = StRound;
         end
         StRound: begin
            for (int i = 0; i < sha_pkg::NumBlockWords - 1; i++) begin
               block_in[i] = block_ff[i+1];
            end
            block_in[sha_pkg::NumBlockWords-1] = next_schedule;
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            round_in   = round_ff + 1'b1;
            if (round_ff == RoundBits'(sha_pkg::NumRounds - 1)) begin
               state_in = StAdd;
            end
         end
         StAdd: begin
            for (int i = 0; i < sha_pkg::NumHashWords; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            case (ret_ff)
               RetPad:  state_in = StPad;
               RetLen:  state_in = StLen;
               RetOut:  state_in = StOut;
               default: state_in = StIdle;
            endcase
         end
         StOut: begin
            if (rsp_accept) begin
               if (rsp_last_word) begin
                  // Digest delivered: start the next message from the initial value.
                  for (int i = 0; i < sha_pkg::NumHashWords; i++) begin
                     hash_in[i] = sha_pkg::init_value(3'(i));
                  end
                  bit_count_in = '0;
                  out_index_in = '0;
                  state_in     = StIdle;
               end else begin
                  out_index_in = out_index_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         ret_ff       <= RetIdle;
         round_ff     <= '0;
         out_index_ff <= '0;
         bit_count_ff <= '0;
         for (int i = 0; i < sha_pkg::NumHashWords; i++) begin
            hash_ff[i] <= sha_pkg::init_value(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         out_index_ff <= out_index_in;
         bit_count_ff <= bit_count_in;
         hash_ff      <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      block_ff <= block_in;
   end

endmodule

`default_nettype wire

[rtl/sha256_stream_hasher_checker.sv]
// Port-level checker for the SHA-256 stream hasher and its bind statement.
`default_nettype none

module sha256_stream_hasher_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   // No new message transaction is taken while digest words are still pending.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("input taken while digest words are pending");

   // The last mark sits exactly on the eighth word.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word does not match word_index");

   // After a delivered word that is not the last, the next word follows at once.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_stall && !rsp_last_word) |=>
                    (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words not delivered in sequence");

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_stall) |=>
                    (rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index)))
      else $error("stalled result changed");

endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);

`default_nettype wire
